// ----- src/moving_average_filter_assert.svh -----
// ----------------------------------------------------------------------------
// Moving average filter assertion macros
// Concurrent assertion helpers clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define MAF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MAF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MAF_ASSERT_IMPL(label, ante, cons, msg)
`define MAF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/maf_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared constants, register map and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int WIN_BITS  = 7;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [WIN_BITS-1:0] WINDOW_RESET = 7'd4;
	localparam logic [APB_AW-1:0]   ADDR_WINDOW  = 3'h0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_START,
		ST_DIV,
		ST_HOLD
	} back_state_t;

endpackage

`default_nettype wire

// ----- src/maf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/maf_front.sv -----
// ----------------------------------------------------------------------------
// Moving average filter front end
// Accept input transactions into a two-entry queue towards the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_front
	import maf_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [TDATA_BITS-1:0]  s_tdata,
	input  wire logic                   s_tlast,
	output logic                        q_valid,
	input  wire logic                   q_ready,
	output logic [SAMPLE_BITS-1:0]      q_sample,
	output logic                        q_last
);

	logic [SAMPLE_BITS-1:0] sample_q [2];
	logic                   last_q   [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic                   push;
	logic                   pop;

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign push     = s_tvalid & s_tready;
	assign pop      = q_valid & q_ready;
	assign q_sample = sample_q[rd_ptr_q];
	assign q_last   = last_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			sample_q[wr_ptr_q] <= s_tdata[SAMPLE_BITS-1:0];
			last_q[wr_ptr_q]   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/maf_div.sv -----
// ----------------------------------------------------------------------------
// Moving average filter divider
// Radix-2 restoring division of a signed sum by an unsigned count,
// truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_div #(
	parameter int SUM_BITS = 22,
	parameter int CNT_BITS = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic signed [SUM_BITS-1:0] dividend,
	input  wire logic [CNT_BITS-1:0]        divisor,
	output logic                            done,
	output logic [SUM_BITS-1:0]             quotient
);

	localparam int STEP_BITS = $clog2(SUM_BITS + 1);

	logic                  busy_q;
	logic                  fix_q;
	logic                  done_q;
	logic                  neg_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [CNT_BITS-1:0]   rem_q;
	logic [CNT_BITS-1:0]   div_q;
	logic [SUM_BITS-1:0]   quo_q;
	logic [CNT_BITS:0]     trial;
	logic                  fits;

	assign trial    = {rem_q, quo_q[SUM_BITS-1]};
	assign fits     = (trial >= {1'b0, div_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[SUM_BITS-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
			rem_q <= fits ? CNT_BITS'(trial - {1'b0, div_q}) : trial[CNT_BITS-1:0];
		end else if (fix_q) begin
			quo_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(SUM_BITS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/maf_back.sv -----
// ----------------------------------------------------------------------------
// Moving average filter back end
// Store each sample in the history ring, sum the newest samples of the
// window, divide by their number and present the result.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_back
	import maf_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [WIN_BITS-1:0]    window,
	input  wire logic                   q_valid,
	output logic                        q_ready,
	input  wire logic [SAMPLE_BITS-1:0] q_sample,
	input  wire logic                   q_last,
	output logic                        busy,
	output logic                        m_valid,
	input  wire logic                   m_ready,
	output logic [SAMPLE_BITS-1:0]      m_average,
	output logic                        m_last
);

	localparam int LOG_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0;
	localparam int ADDR_BITS = (MAX_WINDOW > 1) ? LOG_W : 1;
	localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS  = SAMPLE_BITS + LOG_W;
	localparam int WB        = (CNT_BITS > WIN_BITS) ? CNT_BITS : WIN_BITS;

	back_state_t state_q, state_d;

	logic [CNT_BITS-1:0]        held_q;
	logic [ADDR_BITS-1:0]       wp_q;
	logic [CNT_BITS-1:0]        n_q;
	logic [CNT_BITS-1:0]        iss_q;
	logic [CNT_BITS-1:0]        rcv_q;
	logic [ADDR_BITS-1:0]       addr_q;
	logic                       rvalid_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic                       last_q;
	logic                       out_valid_q;
	logic [SAMPLE_BITS-1:0]     out_avg_q;
	logic                       out_last_q;

	logic [WB-1:0]              win_ext;
	logic [CNT_BITS-1:0]        eff;
	logic [CNT_BITS-1:0]        held_new;
	logic [CNT_BITS-1:0]        n_new;
	logic [ADDR_BITS-1:0]       wp_next;
	logic [ADDR_BITS-1:0]       addr_prev;
	logic                       pop;
	logic                       issue;
	logic                       out_free;
	logic                       load_out;
	logic                       div_start;
	logic                       div_done;
	logic [SUM_BITS-1:0]        div_quo;
	logic [SAMPLE_BITS-1:0]     rdata;
	logic signed [SAMPLE_BITS-1:0] rdata_s;

	assign win_ext   = WB'(window);
	assign eff       = (win_ext == '0) ? CNT_BITS'(1)
		: (win_ext > WB'(MAX_WINDOW)) ? CNT_BITS'(MAX_WINDOW) : CNT_BITS'(win_ext);
	assign held_new  = (held_q == CNT_BITS'(MAX_WINDOW)) ? held_q : held_q + 1'b1;
	assign n_new     = (eff < held_new) ? eff : held_new;
	assign wp_next   = (wp_q == ADDR_BITS'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
	assign addr_prev = (addr_q == '0) ? ADDR_BITS'(MAX_WINDOW - 1) : addr_q - 1'b1;

	assign q_ready   = (state_q == ST_IDLE);
	assign pop       = q_valid & q_ready;
	assign issue     = (state_q == ST_SUM) && (iss_q != n_q);
	assign out_free  = !out_valid_q || m_ready;
	assign rdata_s   = rdata;
	assign busy      = (state_q != ST_IDLE);
	assign m_valid   = out_valid_q;
	assign m_average = out_avg_q;
	assign m_last    = out_last_q;

	maf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW),
		.AW    (ADDR_BITS)
	) u_hist (
		.clk   (clk),
		.we    (pop),
		.waddr (wp_q),
		.wdata (q_sample),
		.re    (issue),
		.raddr (addr_q),
		.rdata (rdata)
	);

	maf_div #(
		.SUM_BITS (SUM_BITS),
		.CNT_BITS (CNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (rvalid_q && (rcv_q + 1'b1 == n_q)) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			wp_q        <= '0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= issue;
			if (pop) begin
				held_q <= q_last ? '0 : held_new;
				wp_q   <= q_last ? '0 : wp_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			n_q    <= n_new;
			iss_q  <= '0;
			rcv_q  <= '0;
			addr_q <= wp_q;
			sum_q  <= '0;
			last_q <= q_last;
		end else begin
			if (issue) begin
				iss_q  <= iss_q + 1'b1;
				addr_q <= addr_prev;
			end
			if (rvalid_q) begin
				sum_q <= sum_q + SUM_BITS'(rdata_s);
				rcv_q <= rcv_q + 1'b1;
			end
		end
		if (load_out) begin
			out_avg_q  <= div_quo[SAMPLE_BITS-1:0];
			out_last_q <= last_q;
		end
	end

endmodule

`default_nettype wire

// ----- src/moving_average_filter.sv -----
// ----------------------------------------------------------------------------
// Moving average filter
// Causal moving average over signed samples with an APB window register.
// ----------------------------------------------------------------------------
// Each sample yields one average of the newest n held samples, n being the
// smaller of the samples held since the last clear and the window register
// (0 reads as 1, values above MAX_WINDOW saturate). A sample with tlast set
// empties the history after its own average. One sample occupies the back
// end for n reads through the single history RAM read port, then for one
// quotient bit per cycle in the serial divider. The back end takes the next
// sample only from its idle state, so it does not start a sample before it
// is through with the last one. A two-entry queue takes new samples while
// the back end works, and the output register holds a result until it is
// taken.
`default_nettype none

module moving_average_filter
	import maf_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// APB register port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [TDATA_BITS-1:0] s_tdata,  // sample
	input  wire logic                  s_tlast,
	// output stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [TDATA_BITS-1:0] m_tdata,  // average
	output logic                       m_tlast
);

	logic [WIN_BITS-1:0]    window_q;
	logic                   q_valid;
	logic                   q_ready;
	logic [SAMPLE_BITS-1:0] q_sample;
	logic                   q_last;
	logic                   back_busy;
	logic [SAMPLE_BITS-1:0] m_average;

	assign pready  = 1'b1;
	assign prdata  = (paddr == ADDR_WINDOW) ? APB_DW'(window_q) : '0;
	assign m_tdata = TDATA_BITS'(m_average);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_WINDOW)) begin
			window_q <= pwdata[WIN_BITS-1:0];
		end
	end

	maf_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TDATA_BITS  (TDATA_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_sample (q_sample),
		.q_last   (q_last)
	);

	maf_back #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.window    (window_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_sample  (q_sample),
		.q_last    (q_last),
		.busy      (back_busy),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_average (m_average),
		.m_last    (m_tlast)
	);

`include "moving_average_filter_assert.svh"

	`MAF_ASSERT_NEXT(a_pop_starts_work, q_valid && q_ready, back_busy,
		"back end idle after taking a queued transaction")
	`MAF_ASSERT_IMPL(a_busy_needs_item, $rose(back_busy), $past(q_valid),
		"back end started without a queued transaction")
	`MAF_ASSERT_IMPL(a_result_from_work, $rose(m_tvalid), $past(back_busy),
		"result presented without back end work")

endmodule

`default_nettype wire
